[src/rsch_pkg.sv]
// rsch_pkg: shared types, widths and codes of the ray / sphere closest-hit unit
// used by rsch_mul, rsch_isqrt and ray_sphere_closest_hit; no dependencies
package rsch_pkg;

	// default sizes handed to the top level
	localparam int DEF_MAX_SPHERES = 16;
	localparam int DEF_FRAC_BITS   = 16;

	// fixed field widths
	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int DIST_W   = 31;
	localparam int SLOT_W   = 4;
	localparam int COUNT_W  = 5;
	localparam int MIND_W   = 17;
	localparam int CFG_W    = 17;

	// datapath widths: operands, products and intermediates
	localparam int OPND_W  = 69;            // signed multiplier operand
	localparam int LIMB_W  = 23;            // three limbs cover an operand magnitude
	localparam int NLIMB   = 3;
	localparam int PROD_W  = 2 * OPND_W;    // signed product
	localparam int OC_W    = 33;            // center minus origin
	localparam int A_W     = 64;            // dir.dir, unsigned
	localparam int H_W     = 68;            // dir.oc, signed
	localparam int C_W     = 68;            // oc.oc - r*r, signed
	localparam int DISC_W  = 136;           // h*h - a*c, signed
	localparam int ROOT_W  = 68;            // floor sqrt of the discriminant
	localparam int NUM_W   = 70;            // h -/+ root, signed

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_SPHERE_COUNT = 1'b0,
		CFG_MIN_DISTANCE = 1'b1
	} cfg_idx_t;

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RAY   = 1'b1;

	// one table entry
	typedef struct packed {
		logic [COORD_W-1:0]  cx;
		logic [COORD_W-1:0]  cy;
		logic [COORD_W-1:0]  cz;
		logic [RADIUS_W-1:0] r;
	} sphere_t;

	// product sequence run on the shared multiplier
	typedef enum logic [3:0] {
		OP_AXX, OP_AYY, OP_AZZ,
		OP_HX,  OP_HY,  OP_HZ,
		OP_CX,  OP_CY,  OP_CZ, OP_CR,
		OP_DH,  OP_DAC
	} mul_op_t;

	// multiplier request
	typedef struct packed {
		logic                     start;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
	} mul_req_t;

endpackage

[src/rsch_mul.sv]
// rsch_mul: signed 69 x 69 bit multiplier, one 23 x 23 limb product per cycle
// depends on rsch_pkg
module rsch_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsch_pkg::mul_req_t              req,
	output logic                            done,
	output logic signed [rsch_pkg::PROD_W-1:0] p
);
	import rsch_pkg::*;

	logic [OPND_W-1:0]   ma_q, mb_q;
	logic [PROD_W-1:0]   acc_q;
	logic [1:0]          i_q, j_q;
	logic                busy_q, neg_q, done_q;
	logic [LIMB_W-1:0]   la, lb;
	logic [2*LIMB_W-1:0] pp;
	logic [PROD_W-1:0]   pp_sh;
	logic [OPND_W-1:0]   abs_a, abs_b;
	logic                last;

	// operand magnitudes
	assign abs_a = req.a[OPND_W-1] ? OPND_W'(-req.a) : OPND_W'(req.a);
	assign abs_b = req.b[OPND_W-1] ? OPND_W'(-req.b) : OPND_W'(req.b);

	// one limb product, placed at its weight
	assign la    = ma_q[LIMB_W*i_q +: LIMB_W];
	assign lb    = mb_q[LIMB_W*j_q +: LIMB_W];
	assign pp    = la * lb;
	assign pp_sh = PROD_W'(pp) << (LIMB_W * (32'(i_q) + 32'(j_q)));
	assign last  = (i_q == 2'(NLIMB - 1)) && (j_q == 2'(NLIMB - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else if (j_q == 2'(NLIMB - 1)) begin
					j_q <= '0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= abs_a;
			mb_q  <= abs_b;
			neg_q <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

[src/rsch_isqrt.sv]
// rsch_isqrt: floor square root of a 136 bit value, two radicand bits per cycle
// depends on rsch_pkg
module rsch_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rsch_pkg::DISC_W-1:0]       radicand,
	output logic                              done,
	output logic [rsch_pkg::ROOT_W-1:0]       root
);
	import rsch_pkg::*;

	localparam int STEPS = DISC_W / 2;
	localparam int SC_W  = $clog2(STEPS + 1);
	localparam int REM_W = ROOT_W + 2;

	logic [DISC_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SC_W-1:0]   cnt_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_n, trial;
	logic              ge;

	// trial subtract of (root << 2) | 1
	assign rem_n = {rem_q, rad_q[DISC_W-1 -: 2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == SC_W'(1));
			if (start) begin
				cnt_q <= SC_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - SC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? REM_W'(rem_n - trial) : REM_W'(rem_n);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[src/ray_sphere_closest_hit.sv]
// ray_sphere_closest_hit: sphere table and closest-hit search over it
// depends on rsch_pkg, rsch_mul, rsch_isqrt
//
// channel   dir   handshake           words
// in        in    in_valid/in_ready   kind 0 table write, kind 1 ray
// out       out   out_valid/out_ready one word per ray
// cfg       in    cfg_we              sphere_count, min_distance
//
// a table write is stored as it is accepted; a ray's time grows with n, the tested entries,
// and is set by the shared limb multiplier (3 products per ray and 9 per sphere), the square
// root (68 steps) and the bit-serial divider (FRAC_BITS + 69 steps per root, near and far root)
// reset clears control and sphere_count and sets min_distance to 66; the sphere table is not cleared
// a finished word waits in the output register; the next item is taken once the ray is done
module ray_sphere_closest_hit #(
	parameter int MAX_SPHERES = rsch_pkg::DEF_MAX_SPHERES,
	parameter int FRAC_BITS   = rsch_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [rsch_pkg::SLOT_W-1:0]       entry_index,
	input  logic signed [rsch_pkg::COORD_W-1:0] pos_x,
	input  logic signed [rsch_pkg::COORD_W-1:0] pos_y,
	input  logic signed [rsch_pkg::COORD_W-1:0] pos_z,
	input  logic [rsch_pkg::RADIUS_W-1:0]     radius_in,
	input  logic signed [rsch_pkg::COORD_W-1:0] dir_x,
	input  logic signed [rsch_pkg::COORD_W-1:0] dir_y,
	input  logic signed [rsch_pkg::COORD_W-1:0] dir_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit_found,
	output logic [rsch_pkg::SLOT_W-1:0]       hit_sphere,
	output logic [rsch_pkg::DIST_W-1:0]       hit_distance,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [rsch_pkg::CFG_W-1:0]        cfg_data
);
	import rsch_pkg::*;

	localparam int IW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CW    = $clog2(MAX_SPHERES + 1);
	localparam int DW    = NUM_W - 1 + FRAC_BITS;
	localparam int DC_W  = $clog2(DW + 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_AMUL = 11'b00000000010,
		S_NEXT = 11'b00000000100,
		S_READ = 11'b00000001000,
		S_SMUL = 11'b00000010000,
		S_DISC = 11'b00000100000,
		S_SQRT = 11'b00001000000,
		S_NUM  = 11'b00010000000,
		S_DIV  = 11'b00100000000,
		S_ACC  = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [COUNT_W-1:0] sphere_count_q;
	logic [MIND_W-1:0]  min_distance_q;

	// ray and per-sphere working registers
	logic signed [COORD_W-1:0] px_q, py_q, pz_q, dx_q, dy_q, dz_q;
	logic signed [OC_W-1:0]    ox_q, oy_q, oz_q;
	logic [RADIUS_W-1:0]       r_q;
	logic [A_W-1:0]            a_q;
	logic signed [H_W-1:0]     h_q;
	logic signed [C_W-1:0]     c_q;
	logic signed [DISC_W-1:0]  disc_q;
	logic [ROOT_W-1:0]         s_q;
	logic                      far_q;
	logic [CW-1:0]             i_q, n_q;
	logic [IW-1:0]             best_i_q;
	logic [DIST_W-1:0]         best_q;
	logic                      found_q;
	mul_op_t                   op_q;
	logic                      mstart_q;

	// divider
	logic [DW-1:0]   div_q;
	logic [A_W-1:0]  rem_q;
	logic [DC_W-1:0] dcnt_q;
	logic [A_W:0]    rem_n;
	logic            dge;

	// table memory
	sphere_t tbl_mem [MAX_SPHERES];
	sphere_t rd_q;

	// output register
	logic              out_valid_q, hit_found_q;
	logic [SLOT_W-1:0] hit_sphere_q;
	logic [DIST_W-1:0] hit_distance_q;

	// units
	mul_req_t                   mreq;
	logic                       mdone, sdone;
	logic signed [PROD_W-1:0]   mp;
	logic [ROOT_W-1:0]          sroot;
	logic                       sstart;

	logic                     in_acc;
	logic signed [NUM_W-1:0]  num;
	logic                     num_pos;
	logic                     big, accept;
	logic [DIST_W-1:0]        tval;

	assign in_ready = state_q == S_IDLE;
	assign in_acc   = in_valid && in_ready;

	// multiplier operands by product step
	always_comb begin
		mreq.start = mstart_q;
		mreq.a     = '0;
		mreq.b     = '0;
		unique case (op_q)
			OP_AXX: begin mreq.a = OPND_W'(dx_q); mreq.b = OPND_W'(dx_q); end
			OP_AYY: begin mreq.a = OPND_W'(dy_q); mreq.b = OPND_W'(dy_q); end
			OP_AZZ: begin mreq.a = OPND_W'(dz_q); mreq.b = OPND_W'(dz_q); end
			OP_HX:  begin mreq.a = OPND_W'(dx_q); mreq.b = OPND_W'(ox_q); end
			OP_HY:  begin mreq.a = OPND_W'(dy_q); mreq.b = OPND_W'(oy_q); end
			OP_HZ:  begin mreq.a = OPND_W'(dz_q); mreq.b = OPND_W'(oz_q); end
			OP_CX:  begin mreq.a = OPND_W'(ox_q); mreq.b = OPND_W'(ox_q); end
			OP_CY:  begin mreq.a = OPND_W'(oy_q); mreq.b = OPND_W'(oy_q); end
			OP_CZ:  begin mreq.a = OPND_W'(oz_q); mreq.b = OPND_W'(oz_q); end
			OP_CR: begin
				mreq.a = $signed(OPND_W'(r_q));
				mreq.b = $signed(OPND_W'(r_q));
			end
			OP_DH:  begin mreq.a = OPND_W'(h_q); mreq.b = OPND_W'(h_q); end
			OP_DAC: begin mreq.a = $signed(OPND_W'(a_q)); mreq.b = OPND_W'(c_q); end
			default: begin mreq.a = '0; mreq.b = '0; end
		endcase
	end

	rsch_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.p      (mp)
	);

	assign sstart = (state_q == S_DISC) && !disc_q[DISC_W-1];

	rsch_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sstart),
		.radicand (DISC_W'(disc_q)),
		.done     (sdone),
		.root     (sroot)
	);

	// root numerator, near or far
	always_comb begin
		if (far_q) begin
			num = NUM_W'(h_q) + $signed(NUM_W'(s_q));
		end else begin
			num = NUM_W'(h_q) - $signed(NUM_W'(s_q));
		end
	end
	assign num_pos = !num[NUM_W-1] && (num != '0);

	// restoring divide step
	assign rem_n = {rem_q, div_q[DW-1]};
	assign dge   = rem_n >= {1'b0, a_q};

	// quotient check
	assign big    = |div_q[DW-1:DIST_W];
	assign tval   = big ? {DIST_W{1'b1}} : div_q[DIST_W-1:0];
	assign accept = big || (div_q[DIST_W-1:0] > DIST_W'(min_distance_q));

	// table write and read
	always_ff @(posedge clk) begin
		if (in_acc && (kind == KIND_WRITE) && (32'(entry_index) < MAX_SPHERES)) begin
			tbl_mem[IW'(entry_index)] <= '{cx: pos_x, cy: pos_y, cz: pos_z, r: radius_in};
		end
		rd_q <= tbl_mem[i_q[IW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_count_q <= '0;
			min_distance_q <= MIND_W'(66);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPHERE_COUNT: sphere_count_q <= cfg_data[COUNT_W-1:0];
				CFG_MIN_DISTANCE: min_distance_q <= cfg_data[MIND_W-1:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstart_q    <= 1'b0;
			op_q        <= OP_AXX;
			i_q         <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			far_q       <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// multiplier start for the next product
			mstart_q <= ((state_q == S_IDLE) && in_acc && (kind == KIND_RAY)) ||
				(((state_q == S_AMUL) || (state_q == S_SMUL)) && mdone &&
					(op_q != OP_AZZ) && (op_q != OP_DAC)) ||
				(state_q == S_READ);
			// output word valid
			if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (kind == KIND_RAY)) begin
						i_q      <= '0;
						n_q      <= (32'(sphere_count_q) > MAX_SPHERES) ?
							CW'(MAX_SPHERES) : CW'(sphere_count_q);
						found_q  <= 1'b0;
						op_q     <= OP_AXX;
						state_q  <= S_AMUL;
					end
				end
				S_AMUL, S_SMUL: begin
					if (mdone) begin
						if (op_q == OP_AZZ) begin
							state_q <= S_NEXT;
						end else if (op_q == OP_DAC) begin
							state_q <= S_DISC;
						end else begin
							op_q     <= mul_op_t'(op_q + 4'd1);
						end
					end
				end
				S_NEXT: begin
					if ((a_q == '0) || (i_q == n_q)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					op_q     <= OP_HX;
					state_q  <= S_SMUL;
				end
				S_DISC: begin
					if (disc_q[DISC_W-1]) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_NEXT;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sdone) begin
						far_q   <= 1'b0;
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					if (num_pos) begin
						dcnt_q  <= DC_W'(DW);
						state_q <= S_DIV;
					end else if (!far_q) begin
						far_q <= 1'b1;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_NEXT;
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - DC_W'(1);
					if (dcnt_q == DC_W'(1)) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (!accept && !far_q) begin
						far_q   <= 1'b1;
						state_q <= S_NUM;
					end else begin
						if (accept && (tval <= best_q)) begin
							found_q <= 1'b1;
						end
						i_q     <= i_q + CW'(1);
						state_q <= S_NEXT;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// ray capture
		if (in_acc && (kind == KIND_RAY)) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			pz_q   <= pos_z;
			dx_q   <= dir_x;
			dy_q   <= dir_y;
			dz_q   <= dir_z;
			best_q <= {DIST_W{1'b1}};
		end
		// center minus origin
		if (state_q == S_READ) begin
			ox_q <= $signed({rd_q.cx[COORD_W-1], rd_q.cx}) - OC_W'(px_q);
			oy_q <= $signed({rd_q.cy[COORD_W-1], rd_q.cy}) - OC_W'(py_q);
			oz_q <= $signed({rd_q.cz[COORD_W-1], rd_q.cz}) - OC_W'(pz_q);
			r_q  <= rd_q.r;
		end
		// product accumulation
		if (mdone) begin
			unique case (op_q)
				OP_AXX:              a_q    <= mp[A_W-1:0];
				OP_AYY, OP_AZZ:      a_q    <= a_q + mp[A_W-1:0];
				OP_HX:               h_q    <= $signed(mp[H_W-1:0]);
				OP_HY, OP_HZ:        h_q    <= h_q + $signed(mp[H_W-1:0]);
				OP_CX:               c_q    <= $signed(mp[C_W-1:0]);
				OP_CY, OP_CZ:        c_q    <= c_q + $signed(mp[C_W-1:0]);
				OP_CR:               c_q    <= c_q - $signed(mp[C_W-1:0]);
				OP_DH:               disc_q <= $signed(mp[DISC_W-1:0]);
				OP_DAC:              disc_q <= disc_q - $signed(mp[DISC_W-1:0]);
				default:             a_q    <= a_q;
			endcase
		end
		if (sdone) begin
			s_q <= sroot;
		end
		// divider load and steps
		if ((state_q == S_NUM) && num_pos) begin
			div_q <= DW'(num[NUM_W-2:0]) << FRAC_BITS;
			rem_q <= '0;
		end else if (state_q == S_DIV) begin
			div_q <= {div_q[DW-2:0], dge};
			rem_q <= dge ? A_W'(rem_n - {1'b0, a_q}) : rem_n[A_W-1:0];
		end
		// closest hit, later sphere wins a tie
		if ((state_q == S_ACC) && accept && (tval <= best_q)) begin
			best_q   <= tval;
			best_i_q <= i_q[IW-1:0];
		end
		// result word
		if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
			hit_found_q    <= found_q;
			hit_sphere_q   <= found_q ? SLOT_W'(best_i_q) : '0;
			hit_distance_q <= found_q ? best_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_found    = hit_found_q;
	assign hit_sphere   = hit_sphere_q;
	assign hit_distance = hit_distance_q;

endmodule
